// File: rtl/trm_pkg.sv
// trm_pkg: shared types and constants for the fan tachometer rpm meter
// no dependencies; imported by trm_cell, trm_div and tacho_rpm_median_meter
`default_nettype none

package trm_pkg;

  localparam int unsigned CNT_W     = 16;  // edge counter and timer width
  localparam int unsigned RPM_W     = 16;
  localparam int unsigned PPR_W     = 4;
  localparam int unsigned PROD_W    = 22;  // edges * 60 fits here
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = 16;

  localparam logic [PROD_W-1:0]    RPM_PER_MIN  = PROD_W'(60);
  localparam logic [PPR_W-1:0]     PPR_RESET    = PPR_W'(2);
  localparam logic [CNT_W-1:0]     DEB_RESET    = CNT_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PPR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEB = 1'b1;

  typedef struct packed {
    logic             edge_seen;
    logic [CNT_W-1:0] timer_value;
    logic             gate_end;
    logic             read_ack;
  } in_word_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm_recent;
    logic [RPM_W-1:0] rpm_filtered;
    logic             fan_stopped;
    logic             new_measurement;
    logic [CNT_W-1:0] edges_so_far;
  } out_word_t;

  // compare flags of one window cell against the broadcast candidate
  typedef struct packed {
    logic lt;
    logic le;
  } cell_cmp_t;

endpackage

`default_nettype wire

// File: rtl/trm_cell.sv
// trm_cell: one entry of the rpm window ring; holds a value and its valid bit
// depends on trm_pkg; instanced in a chain by tacho_rpm_median_meter
`default_nettype none

module trm_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        shift_en,
  input  wire [trm_pkg::RPM_W-1:0]   chain_val,
  input  wire                        chain_vld,
  input  wire [trm_pkg::RPM_W-1:0]   cand,
  output logic [trm_pkg::RPM_W-1:0]  val,
  output logic                       vld,
  output trm_pkg::cell_cmp_t         cmp
);
  import trm_pkg::*;

  logic [RPM_W-1:0] val_r;
  logic             vld_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= chain_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift_en) begin
      vld_r <= chain_vld;
    end
  end

  always_comb begin
    cmp.lt = vld_r && (val_r < cand);
    cmp.le = vld_r && (val_r <= cand);
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

`default_nettype wire

// File: rtl/trm_div.sv
// trm_div: restoring divider, one quotient bit per cycle, for edges*60 / pulses
// depends on trm_pkg; used by tacho_rpm_median_meter
`default_nettype none

module trm_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [trm_pkg::PROD_W-1:0]  dividend,
  input  wire [trm_pkg::PPR_W-1:0]   divisor,
  output logic                       done,
  output logic [trm_pkg::PROD_W-1:0] quotient
);
  import trm_pkg::*;

  localparam int unsigned STEP_W = $clog2(PROD_W);

  logic [PROD_W-1:0] quo_r;
  logic [PPR_W-1:0]  rem_r;
  logic [PPR_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [PPR_W:0]    trial;
  logic              q_bit;
  logic [PPR_W-1:0]  rem_nxt;

  always_comb begin
    trial = {rem_r, quo_r[PROD_W-1]};
    q_bit = (trial >= {1'b0, div_r});
    if (q_bit) begin
      rem_nxt = PPR_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[PPR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[PROD_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/tacho_rpm_median_meter.sv
// Fan tachometer rpm meter with a median filter. One input word is one timer tick
// and gives one result word showing the state after that tick. A tick without gate
// end has its result word registered as the tick is taken, so such words stream at
// one per clock while the output is accepted. A tick with gate end first runs the
// bit-serial divider that forms edges*60/pulses_per_rev, then the ring of window
// cells rotates once past a rank counter that picks out the median. The result
// register is refilled in the cycle its word leaves, so a new tick word is taken in
// the same cycle the previous result is accepted, never while it is still waiting.
// tacho_rpm_median_meter: top level; depends on trm_pkg, trm_cell, trm_div
`default_nettype none

module tacho_rpm_median_meter #(
  parameter int unsigned WINDOW_DEPTH = 5
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire trm_pkg::in_word_t        in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output trm_pkg::out_word_t            out_data,
  input  wire                           cfg_we,
  input  wire [trm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [trm_pkg::CFG_DW-1:0]     cfg_wdata
);
  import trm_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MED  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t           state_r;
  logic [PPR_W-1:0] ppr_r;
  logic [CNT_W-1:0] deb_r;
  logic [CNT_W-1:0] edge_cnt_r;
  logic [CNT_W-1:0] last_time_r;
  logic [RPM_W-1:0] recent_r;
  logic [RPM_W-1:0] median_r;
  logic             new_r;
  logic             stop_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] rot_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic              in_acc;
  logic [CNT_W-1:0]  tick_gap;
  logic              edge_ok;
  logic [CNT_W-1:0]  cnt_after;
  logic              div_start;
  logic [PROD_W-1:0] dividend;
  logic [PPR_W-1:0]  divisor;
  logic              div_done;
  logic [PROD_W-1:0] quotient;
  logic [RPM_W-1:0]  rpm_sat;
  logic              insert;
  logic              shift_en;
  logic              out_free;
  logic              idle_load;
  logic              out_load;
  logic [FILL_W-1:0] lt_cnt;
  logic [FILL_W-1:0] le_cnt;
  logic [FILL_W-1:0] rank_k;
  logic              med_hit;

  logic [RPM_W-1:0] cell_val [WINDOW_DEPTH];
  logic             cell_vld [WINDOW_DEPTH];
  cell_cmp_t        cell_cmp [WINDOW_DEPTH];
  logic [RPM_W-1:0] head_val;
  logic             head_vld;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  // debounce on the modular timer distance
  always_comb begin
    tick_gap = in_data.timer_value - last_time_r;
    edge_ok  = in_data.edge_seen && (tick_gap > deb_r);
    if (edge_ok && (edge_cnt_r != {CNT_W{1'b1}})) begin
      cnt_after = edge_cnt_r + CNT_W'(1);
    end else begin
      cnt_after = edge_cnt_r;
    end
  end

  assign div_start = in_acc && in_data.gate_end;
  assign dividend  = PROD_W'(cnt_after) * RPM_PER_MIN;
  assign divisor   = (ppr_r == '0) ? PPR_W'(1) : ppr_r;

  trm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign rpm_sat = (quotient[PROD_W-1:RPM_W] != '0) ? {RPM_W{1'b1}} : quotient[RPM_W-1:0];

  // window ring: a new rpm enters at the head, the ring then rotates once around
  assign insert   = (state_r == S_DIV) && div_done;
  assign shift_en = insert || (state_r == S_MED);
  assign head_val = insert ? rpm_sat : cell_val[WINDOW_DEPTH-1];
  assign head_vld = insert ? 1'b1 : cell_vld[WINDOW_DEPTH-1];

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
      logic [RPM_W-1:0] chain_val;
      logic             chain_vld;
      if (gi == 0) begin : g_head
        assign chain_val = head_val;
        assign chain_vld = head_vld;
      end else begin : g_link
        assign chain_val = cell_val[gi-1];
        assign chain_vld = cell_vld[gi-1];
      end
      trm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (shift_en),
        .chain_val (chain_val),
        .chain_vld (chain_vld),
        .cand      (cell_val[0]),
        .val       (cell_val[gi]),
        .vld       (cell_vld[gi]),
        .cmp       (cell_cmp[gi])
      );
    end
  endgenerate

  // head value is the median when its rank window covers fill/2
  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      lt_cnt = lt_cnt + FILL_W'(cell_cmp[i].lt);
      le_cnt = le_cnt + FILL_W'(cell_cmp[i].le);
    end
    rank_k  = fill_r >> 1;
    med_hit = cell_vld[0] && (lt_cnt <= rank_k) && (le_cnt > rank_k);
  end

  assign idle_load = in_acc && !in_data.gate_end;
  assign out_load  = idle_load || ((state_r == S_OUT) && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ppr_r       <= PPR_RESET;
      deb_r       <= DEB_RESET;
      edge_cnt_r  <= '0;
      last_time_r <= '0;
      recent_r    <= '0;
      median_r    <= '0;
      new_r       <= 1'b0;
      stop_r      <= 1'b0;
      fill_r      <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_PPR: ppr_r <= cfg_wdata[PPR_W-1:0];
          CFG_IDX_DEB: deb_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (edge_ok) begin
              last_time_r <= in_data.timer_value;
            end
            if (in_data.read_ack) begin
              new_r <= 1'b0;
            end
            if (in_data.gate_end) begin
              edge_cnt_r <= '0;
              stop_r     <= (cnt_after == '0);
              state_r    <= S_DIV;
            end else begin
              edge_cnt_r <= cnt_after;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            recent_r <= rpm_sat;
            rot_r    <= '0;
            if (fill_r != FILL_W'(WINDOW_DEPTH)) begin
              fill_r <= fill_r + FILL_W'(1);
            end
            state_r <= S_MED;
          end
        end
        S_MED: begin
          if (med_hit) begin
            median_r <= cell_val[0];
          end
          rot_r <= rot_r + FILL_W'(1);
          if (rot_r == FILL_W'(WINDOW_DEPTH - 1)) begin
            new_r   <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (idle_load) begin
      out_data_r.rpm_recent      <= recent_r;
      out_data_r.rpm_filtered    <= median_r;
      out_data_r.fan_stopped     <= stop_r;
      out_data_r.new_measurement <= new_r && !in_data.read_ack;
      out_data_r.edges_so_far    <= cnt_after;
    end else if (out_load) begin
      out_data_r.rpm_recent      <= recent_r;
      out_data_r.rpm_filtered    <= median_r;
      out_data_r.fan_stopped     <= stop_r;
      out_data_r.new_measurement <= new_r;
      out_data_r.edges_so_far    <= edge_cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_gate_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DIV) && !div_done)
    else $error("gate end did not start the divider");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  // the new entry sits at the head only in the first scan cycle
  a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MED) && (rot_r == '0)) |-> (fill_r != '0) && cell_vld[0])
    else $error("median scan over an empty window");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill count beyond depth");

  a_new_after_gate: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && out_free) |=> out_valid_r && out_data_r.new_measurement)
    else $error("gate result not flagged as new");
`endif

endmodule

`default_nettype wire
